@@ rtl/sacp_pkg.sv @@
package sacp_pkg;

	typedef struct packed {
		logic [5:0]  set_index;
		logic [31:0] tag_value;
		logic [5:0]  next_set_index;
		logic [31:0] next_tag_value;
		logic        is_write;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [1:0]  reads_issued;
		logic        write_issued;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
		logic [31:0] read_total;
		logic [31:0] write_total;
	} rsp_t;

	localparam int unsigned CFG_IDX_BITS = 2;
	localparam int unsigned CFG_DATA_BITS = 4;
	localparam logic [CFG_IDX_BITS-1:0] REG_WAYS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIFO = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PREF = 2'd2;

	localparam int unsigned AGE_BITS = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_DREAD,
		ST_DWRITE,
		ST_PREAD,
		ST_PWRITE,
		ST_DONE
	} state_t;

	// saturating age increment
	function automatic logic [AGE_BITS-1:0] sat_inc(input logic [AGE_BITS-1:0] a);
		sat_inc = (a == {AGE_BITS{1'b1}}) ? a : a + 1'b1;
	endfunction

endpackage

@@ rtl/sacp_ram.sv @@
module sacp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/sacp_set_update.sv @@
// computes lookup, fill and aging for one whole set row
module sacp_set_update #(
	parameter int unsigned MAX_WAYS = 8,
	parameter int unsigned TAG_BITS = 32
) (
	input  logic [MAX_WAYS-1:0]                       valid_in,
	input  logic [MAX_WAYS-1:0][TAG_BITS-1:0]         tag_in,
	input  logic [MAX_WAYS-1:0][sacp_pkg::AGE_BITS-1:0] fage_in,
	input  logic [MAX_WAYS-1:0][sacp_pkg::AGE_BITS-1:0] uage_in,
	input  logic [MAX_WAYS-1:0]                       way_on,
	input  logic [TAG_BITS-1:0]                       tag,
	input  logic                                      fifo_mode,
	input  logic                                      do_update,
	output logic                                      found,
	output logic [MAX_WAYS-1:0]                       valid_out,
	output logic [MAX_WAYS-1:0][TAG_BITS-1:0]         tag_out,
	output logic [MAX_WAYS-1:0][sacp_pkg::AGE_BITS-1:0] fage_out,
	output logic [MAX_WAYS-1:0][sacp_pkg::AGE_BITS-1:0] uage_out
);

	localparam int unsigned WB = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	logic [MAX_WAYS-1:0] hit_vec;
	logic [WB-1:0]       hit_way;
	logic                free;
	logic [WB-1:0]       free_way;
	logic [WB-1:0]       vic_way;
	logic [sacp_pkg::AGE_BITS-1:0] best;
	logic [sacp_pkg::AGE_BITS-1:0] cand;

	// tag compare and priority picks
	always_comb begin
		hit_vec = '0;
		hit_way = '0;
		free = 1'b0;
		free_way = '0;
		vic_way = '0;
		best = '0;
		cand = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			hit_vec[i] = way_on[i] && valid_in[i] && (tag_in[i] == tag);
			if (hit_vec[i]) begin
				hit_way = WB'(i);
			end
			if (way_on[i] && !valid_in[i]) begin
				free = 1'b1;
				free_way = WB'(i);
			end
		end
		for (int i = 0; i < MAX_WAYS; i++) begin
			cand = fifo_mode ? fage_in[i] : uage_in[i];
			if (way_on[i] && cand > best) begin
				best = cand;
				vic_way = WB'(i);
			end
		end
		found = |hit_vec;
	end

	// new row contents
	always_comb begin
		valid_out = valid_in;
		tag_out = tag_in;
		fage_out = fage_in;
		uage_out = uage_in;
		if (do_update) begin
			for (int i = 0; i < MAX_WAYS; i++) begin
				if (found) begin
					if (way_on[i]) begin
						uage_out[i] = (WB'(i) == hit_way) ? '0 : sacp_pkg::sat_inc(uage_in[i]);
					end
				end else if (way_on[i]) begin
					if (WB'(i) == (free ? free_way : vic_way)) begin
						valid_out[i] = 1'b1;
						tag_out[i] = tag;
						fage_out[i] = '0;
						uage_out[i] = '0;
					end else if (!free || valid_in[i]) begin
						fage_out[i] = sacp_pkg::sat_inc(fage_in[i]);
						uage_out[i] = sacp_pkg::sat_inc(uage_in[i]);
					end
				end
			end
		end
	end

endmodule

@@ rtl/set_assoc_cache_with_prefetch.sv @@
// channel  | direction | handshake             | payload
// cfg      | in        | cfg_we                | cfg_idx, cfg_data
// request  | in        | start && !busy        | req (sacp_pkg::req_t)
// result   | out       | done (one cycle)      | rsp (sacp_pkg::rsp_t)
// An access on a hit or without prefetch steps through set read and write-back.
// With prefetch on a miss the next set is also read, after the demand
// write-back has landed, and is then written, on the same set memory.
// After reset a clearing pass over every set empties the set memory; busy
// stays high meanwhile. The receiver cannot stall; done lasts one cycle.
module set_assoc_cache_with_prefetch #(
	parameter int unsigned NUM_SETS = 64,
	parameter int unsigned MAX_WAYS = 8,
	parameter int unsigned TAG_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sacp_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [sacp_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              start,
	input  sacp_pkg::req_t                    req,
	output logic                              busy,
	output logic                              done,
	output sacp_pkg::rsp_t                    rsp
);

	localparam int unsigned AB = sacp_pkg::AGE_BITS;
	localparam int unsigned SB = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int unsigned ROW_W = MAX_WAYS * (1 + TAG_BITS + 2 * AB);

	typedef struct packed {
		logic [MAX_WAYS-1:0]               valid;
		logic [MAX_WAYS-1:0][TAG_BITS-1:0] tag;
		logic [MAX_WAYS-1:0][AB-1:0]       fage;
		logic [MAX_WAYS-1:0][AB-1:0]       uage;
	} row_t;

	sacp_pkg::state_t state_q, state_d;

	logic [3:0]  ways_q;
	logic        fifo_q;
	logic        pref_q;
	logic [SB-1:0] clr_q;

	logic [SB-1:0]       dset_q, pset_q;
	logic [TAG_BITS-1:0] dtag_q, ptag_q;
	logic                wr_q;
	logic                hit_q;
	logic [1:0]          reads_q;
	logic [MAX_WAYS-1:0] way_on;

	logic [31:0] hits_q, misses_q, rtot_q, wtot_q;

	row_t rd_row, new_row;
	logic [TAG_BITS-1:0] cur_tag;
	logic                found;
	logic                mem_we;
	logic [SB-1:0]       mem_waddr, mem_raddr;
	row_t                mem_wdata;
	logic                pref_go;

	// set index folded into range through a small constant table
	function automatic logic [SB-1:0] set_of(input logic [5:0] s);
		logic [31:0] w;
		w = '0;
		for (int v = 0; v < 64; v++) begin
			if (s == 6'(v)) begin
				w = 32'(v) % NUM_SETS;
			end
		end
		set_of = w[SB-1:0];
	endfunction

	// ways enabled from the clamped associativity
	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			way_on[i] = (i == 0) || (32'(i) < 32'(ways_q));
		end
	end

	assign cur_tag = (state_q == sacp_pkg::ST_PWRITE) ? ptag_q : dtag_q;

	sacp_set_update #(
		.MAX_WAYS (MAX_WAYS),
		.TAG_BITS (TAG_BITS)
	) u_upd (
		.valid_in  (rd_row.valid),
		.tag_in    (rd_row.tag),
		.fage_in   (rd_row.fage),
		.uage_in   (rd_row.uage),
		.way_on    (way_on),
		.tag       (cur_tag),
		.fifo_mode (fifo_q),
		.do_update ((state_q == sacp_pkg::ST_DWRITE) || !found),
		.found     (found),
		.valid_out (new_row.valid),
		.tag_out   (new_row.tag),
		.fage_out  (new_row.fage),
		.uage_out  (new_row.uage)
	);

	assign pref_go = pref_q && !found;

	// set memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = dset_q;
		mem_wdata = new_row;
		mem_raddr = dset_q;
		unique case (state_q)
			sacp_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			sacp_pkg::ST_DWRITE: begin
				mem_we = 1'b1;
			end
			sacp_pkg::ST_PREAD: begin
				mem_raddr = pset_q;
			end
			sacp_pkg::ST_PWRITE: begin
				mem_we = 1'b1;
				mem_waddr = pset_q;
			end
			default: begin
			end
		endcase
	end

	sacp_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_row)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sacp_pkg::ST_CLEAR:  if (32'(clr_q) == NUM_SETS - 1) state_d = sacp_pkg::ST_IDLE;
			sacp_pkg::ST_IDLE:   if (start) state_d = sacp_pkg::ST_DREAD;
			sacp_pkg::ST_DREAD:  state_d = sacp_pkg::ST_DWRITE;
			sacp_pkg::ST_DWRITE: state_d = (!found && pref_q) ? sacp_pkg::ST_PREAD
			                                                  : sacp_pkg::ST_DONE;
			sacp_pkg::ST_PREAD:  state_d = sacp_pkg::ST_PWRITE;
			sacp_pkg::ST_PWRITE: state_d = sacp_pkg::ST_DONE;
			sacp_pkg::ST_DONE:   state_d = sacp_pkg::ST_IDLE;
			default:             state_d = sacp_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy = (state_q != sacp_pkg::ST_IDLE);
		done = (state_q == sacp_pkg::ST_DONE);
		rsp.hit = hit_q;
		rsp.reads_issued = reads_q;
		rsp.write_issued = wr_q;
		rsp.hit_total = hits_q;
		rsp.miss_total = misses_q;
		rsp.read_total = rtot_q;
		rsp.write_total = wtot_q;
	end

	// control and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sacp_pkg::ST_CLEAR;
			clr_q <= '0;
			ways_q <= 4'd1;
			fifo_q <= 1'b0;
			pref_q <= 1'b0;
			hits_q <= '0;
			misses_q <= '0;
			rtot_q <= '0;
			wtot_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sacp_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					sacp_pkg::REG_WAYS: ways_q <= cfg_data;
					sacp_pkg::REG_FIFO: fifo_q <= cfg_data[0];
					sacp_pkg::REG_PREF: pref_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (state_q == sacp_pkg::ST_DWRITE) begin
				if (found) begin
					hits_q <= hits_q + 1'b1;
				end else begin
					misses_q <= misses_q + 1'b1;
				end
				wtot_q <= wtot_q + 32'(wr_q);
				rtot_q <= rtot_q + 32'(!found);
			end
			if (state_q == sacp_pkg::ST_PWRITE && !found) begin
				rtot_q <= rtot_q + 1'b1;
			end
		end
	end

	// payload of the access in flight
	always_ff @(posedge clk) begin
		if (state_q == sacp_pkg::ST_IDLE && start) begin
			dset_q <= set_of(req.set_index);
			pset_q <= set_of(req.next_set_index);
			dtag_q <= req.tag_value[TAG_BITS-1:0];
			ptag_q <= req.next_tag_value[TAG_BITS-1:0];
			wr_q <= req.is_write;
		end
		if (state_q == sacp_pkg::ST_DWRITE) begin
			hit_q <= found;
			reads_q <= found ? 2'd0 : 2'd1;
		end
		if (state_q == sacp_pkg::ST_PWRITE && pref_go) begin
			reads_q <= 2'd2;
		end
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

	localparam int unsigned N_SETS = 64;
	localparam int unsigned N_WAYS = 8;
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [sacp_pkg::CFG_IDX_BITS-1:0] cfg_idx;
	logic [sacp_pkg::CFG_DATA_BITS-1:0] cfg_data;
	logic start;
	sacp_pkg::req_t req;
	logic busy;
	logic done;
	sacp_pkg::rsp_t rsp;

	set_assoc_cache_with_prefetch i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	// predicted tag store and settings
	logic        tv_valid [N_SETS][N_WAYS];
	logic [31:0] tv_tag [N_SETS][N_WAYS];
	logic [31:0] tv_fage [N_SETS][N_WAYS];
	logic [31:0] tv_uage [N_SETS][N_WAYS];
	logic [31:0] n_hits, n_misses, n_reads, n_writes;
	logic [3:0]  cur_ways;
	logic        cur_fifo;
	logic        cur_pref;

	sacp_pkg::rsp_t pending_rsp [$];
	int unsigned n_errors;
	int unsigned n_sent;
	int unsigned n_checked;
	int unsigned n_pref_fills;
	int unsigned cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [31:0] age_up(input logic [31:0] a);
		return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
	endfunction

	function automatic int unsigned ways_now();
		if (cur_ways == 0) return 1;
		if (cur_ways > N_WAYS) return N_WAYS;
		return cur_ways;
	endfunction

	function automatic int lookup_way(input int unsigned s, input logic [31:0] t,
			input int unsigned nw);
		for (int unsigned i = 0; i < nw; i++)
			if (tv_valid[s][i] && tv_tag[s][i] == t) return int'(i);
		return -1;
	endfunction

	// install a line with free-way fill or FIFO/LRU replacement
	task automatic install_line(input int unsigned s, input logic [31:0] t,
			input int unsigned nw);
		int unsigned victim;
		bit got_free;
		logic [31:0] best, a;
		victim = 0;
		got_free = 0;
		for (int unsigned i = 0; i < nw; i++)
			if (!got_free && !tv_valid[s][i]) begin
				victim = i;
				got_free = 1;
			end
		if (got_free) begin
			for (int unsigned i = 0; i < nw; i++)
				if (tv_valid[s][i]) begin
					tv_fage[s][i] = age_up(tv_fage[s][i]);
					tv_uage[s][i] = age_up(tv_uage[s][i]);
				end
			tv_valid[s][victim] = 1'b1;
		end else begin
			best = 0;
			for (int unsigned i = 0; i < nw; i++) begin
				a = cur_fifo ? tv_fage[s][i] : tv_uage[s][i];
				if (a > best) begin
					best = a;
					victim = i;
				end
			end
			for (int unsigned i = 0; i < nw; i++)
				if (i != victim) begin
					tv_fage[s][i] = age_up(tv_fage[s][i]);
					tv_uage[s][i] = age_up(tv_uage[s][i]);
				end
		end
		tv_tag[s][victim] = t;
		tv_fage[s][victim] = 0;
		tv_uage[s][victim] = 0;
	endtask

	// compute the response of one access and update the predicted store
	task automatic predict_access(input sacp_pkg::req_t r);
		int unsigned nw, s, ps;
		int hw;
		sacp_pkg::rsp_t e;
		nw = ways_now();
		s = r.set_index;
		ps = r.next_set_index;
		e = '0;
		hw = lookup_way(s, r.tag_value, nw);
		if (hw >= 0) begin
			e.hit = 1'b1;
			n_hits++;
			for (int unsigned i = 0; i < nw; i++)
				if (i != hw) tv_uage[s][i] = age_up(tv_uage[s][i]);
			tv_uage[s][hw] = 0;
		end else begin
			n_misses++;
			e.reads_issued = 2'd1;
			install_line(s, r.tag_value, nw);
			if (cur_pref && lookup_way(ps, r.next_tag_value, nw) < 0) begin
				e.reads_issued = 2'd2;
				n_pref_fills++;
				install_line(ps, r.next_tag_value, nw);
			end
		end
		n_reads += 32'(e.reads_issued);
		n_writes += 32'(r.is_write);
		e.write_issued = r.is_write;
		e.hit_total = n_hits;
		e.miss_total = n_misses;
		e.read_total = n_reads;
		e.write_total = n_writes;
		pending_rsp.push_back(e);
	endtask

	// result checker
	always @(posedge clk) begin
		sacp_pkg::rsp_t e;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("unexpected result %h", rsp);
			end else begin
				e = pending_rsp.pop_front();
				n_checked++;
				if (rsp.hit !== e.hit || rsp.reads_issued !== e.reads_issued
						|| rsp.write_issued !== e.write_issued
						|| rsp.hit_total !== e.hit_total
						|| rsp.miss_total !== e.miss_total
						|| rsp.read_total !== e.read_total
						|| rsp.write_total !== e.write_total) begin
					n_errors++;
					if (n_errors <= 10) begin
						$display("mismatch on result %0d", n_checked);
						$display("  exp hit=%0b rd=%0d wr=%0b tot=%0d/%0d/%0d/%0d",
							e.hit, e.reads_issued, e.write_issued, e.hit_total,
							e.miss_total, e.read_total, e.write_total);
						$display("  got hit=%0b rd=%0d wr=%0b tot=%0d/%0d/%0d/%0d",
							rsp.hit, rsp.reads_issued, rsp.write_issued, rsp.hit_total,
							rsp.miss_total, rsp.read_total, rsp.write_total);
					end
				end
			end
		end
	end

	// one transfer on the request port
	task automatic send_access(input sacp_pkg::req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_access(r);
		n_sent++;
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_gap();
		int unsigned g;
		g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		repeat (g) @(posedge clk);
	endtask

	task automatic wait_drain();
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sacp_pkg::CFG_IDX_BITS-1:0] idx,
			input logic [sacp_pkg::CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sacp_pkg::REG_WAYS: cur_ways = val;
			sacp_pkg::REG_FIFO: cur_fifo = val[0];
			sacp_pkg::REG_PREF: cur_pref = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_mode(input logic [3:0] w, input logic f, input logic p);
		wait_drain();
		write_reg(sacp_pkg::REG_WAYS, w);
		write_reg(sacp_pkg::REG_FIFO, {3'b0, f});
		write_reg(sacp_pkg::REG_PREF, {3'b0, p});
	endtask

	function automatic sacp_pkg::req_t make_access(input int unsigned s,
			input logic [31:0] t, input int unsigned ns, input logic [31:0] nt,
			input logic w);
		sacp_pkg::req_t r;
		r.set_index = 6'(s);
		r.tag_value = t;
		r.next_set_index = 6'(ns);
		r.next_tag_value = nt;
		r.is_write = w;
		return r;
	endfunction

	// directed: field extremes, hit, fill, eviction, prefetch in same set
	task automatic test_directed();
		set_mode(4'd2, 1'b0, 1'b1);
		send_access(make_access(0, 32'h0, 63, 32'hFFFF_FFFF, 1'b0));
		send_access(make_access(0, 32'h0, 63, 32'hFFFF_FFFF, 1'b1));
		send_access(make_access(63, 32'hFFFF_FFFF, 0, 32'h0, 1'b1));
		send_access(make_access(5, 32'h10, 5, 32'h11, 1'b0));
		send_access(make_access(5, 32'h12, 5, 32'h11, 1'b0));
		send_access(make_access(5, 32'h11, 6, 32'h1, 1'b1));
		send_access(make_access(5, 32'h13, 5, 32'h14, 1'b0));
		set_mode(4'd0, 1'b1, 1'b0);
		send_access(make_access(7, 32'hA5A5_A5A5, 8, 32'h5A5A_5A5A, 1'b0));
		send_access(make_access(7, 32'hA5A5_A5A5, 8, 32'h0, 1'b1));
		send_access(make_access(7, 32'h5A5A_5A5A, 8, 32'h0, 1'b0));
		set_mode(4'd15, 1'b1, 1'b1);
		for (int i = 0; i < 10; i++)
			send_access(make_access(9, 32'(i), 9, 32'(i + 100), i[0]));
		send_access(make_access(9, 3, 10, 1, 1'b0));
	endtask

	// random: small tag pool per set so hits and evictions are frequent
	task automatic test_random(input int unsigned count);
		sacp_pkg::req_t r;
		int unsigned burst;
		burst = 0;
		for (int unsigned k = 0; k < count; k++) begin
			if (burst == 0) begin
				random_gap();
				burst = $urandom_range(1, 20);
			end
			burst--;
			if ($urandom_range(0, 9) == 0) begin
				r = sacp_pkg::req_t'($bits(sacp_pkg::req_t)'({$urandom, $urandom, $urandom}));
			end else begin
				r.set_index = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
					: 6'($urandom_range(0, 3));
				r.tag_value = $urandom_range(0, 11);
				if ($urandom_range(0, 7) == 0) r.tag_value = ~r.tag_value;
				r.next_set_index = ($urandom_range(0, 1) != 0) ? r.set_index + 6'd1
					: 6'($urandom_range(0, 63));
				r.next_tag_value = $urandom_range(0, 11);
				r.is_write = 1'($urandom_range(0, 1));
			end
			send_access(r);
		end
	endtask

	// settings sweep with random traffic
	task automatic test_modes();
		set_mode(4'd1, 1'b0, 1'b0);
		test_random(120);
		set_mode(4'd8, 1'b0, 1'b0);
		test_random(120);
		set_mode(4'd4, 1'b1, 1'b0);
		test_random(120);
		set_mode(4'd8, 1'b1, 1'b1);
		test_random(120);
		// full pause with nothing outstanding
		wait_drain();
		set_mode(4'd3, 1'b0, 1'b1);
		test_random(120);
		set_mode(4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom));
		test_random(180);
	endtask

	initial begin
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		cycles = 0;
		n_errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_pref_fills = 0;
		n_hits = 0;
		n_misses = 0;
		n_reads = 0;
		n_writes = 0;
		cur_ways = 4'd1;
		cur_fifo = 1'b0;
		cur_pref = 1'b0;
		for (int s = 0; s < N_SETS; s++)
			for (int w = 0; w < N_WAYS; w++) begin
				tv_valid[s][w] = 1'b0;
				tv_tag[s][w] = '0;
				tv_fage[s][w] = '0;
				tv_uage[s][w] = '0;
			end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_modes();
		wait_drain();

		$display("covered %0d accesses, %0d results checked, %0d hits, %0d prefetch fills",
			n_sent, n_checked, n_hits, n_pref_fills);
		if (n_errors == 0 && pending_rsp.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d errors, %0d results missing", n_errors, pending_rsp.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/sacp_pkg.sv
rtl/sacp_ram.sv
rtl/sacp_set_update.sv
rtl/set_assoc_cache_with_prefetch.sv
bench/tb.sv
